// ===== hw/rtl/dtc_pkg.sv =====
// Package for the differential drive turn control unit.
// Holds register reset values, the turn mode codes, register indexes and
// the divider control and result types. No dependencies.
`default_nettype none

package dtc_pkg;

   // Field widths
   localparam int ANGLE_W  = 16;
   localparam int THR_W    = 15;
   localparam int SPEED_W  = 16;
   localparam int OUT_W    = 17;
   localparam int MAG_W    = 17;
   localparam int PROD_W   = SPEED_W + THR_W;
   localparam int CSR_IDX_W = 2;

   // Register reset values
   localparam logic [THR_W-1:0]   HARD_THR_RESET     = 15'd7282;
   localparam logic [THR_W-1:0]   SOFT_THR_RESET     = 15'd5825;
   localparam logic [THR_W-1:0]   STRAIGHT_THR_RESET = 15'd1456;
   localparam logic [SPEED_W-1:0] MAX_SPEED_RESET    = 16'd2560;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HARD_THR     = 2'd0,
      CSR_SOFT_THR     = 2'd1,
      CSR_STRAIGHT_THR = 2'd2,
      CSR_MAX_SPEED    = 2'd3
   } csr_index_type;

   // Turning mode codes
   typedef enum logic [1:0] {
      MODE_STRAIGHT = 2'd0,
      MODE_SOFT     = 2'd1,
      MODE_HARD     = 2'd2
   } turn_mode_type;

   // Divider control: start loads dividend and divisor
   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [THR_W-1:0]  divisor;
   } div_ctrl_type;

   // Divider result: done pulses once the quotient is settled
   typedef struct packed {
      logic               done;
      logic [SPEED_W-1:0] quotient;
      logic               rem_nonzero;
   } div_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dtc_req_if.sv =====
// Request channel of the turn control unit: heading angle and length.
// Depends on dtc_pkg for field widths.
`default_nettype none

interface dtc_req_if
   import dtc_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [ANGLE_W-1:0]  heading_angle;
   logic        [SPEED_W-1:0]  heading_length;

   modport source (output valid, heading_angle, heading_length, input ready);
   modport sink   (input valid, heading_angle, heading_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dtc_rsp_if.sv =====
// Response channel of the turn control unit: wheel speeds and turn mode.
// Depends on dtc_pkg for field widths.
`default_nettype none

interface dtc_rsp_if
   import dtc_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  left_speed;
   logic signed [OUT_W-1:0]  right_speed;
   logic        [1:0]        turn_mode;

   modport source (output valid, left_speed, right_speed, turn_mode, input ready);
   modport sink   (input valid, left_speed, right_speed, turn_mode, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dtc_mode_next.sv =====
// Hysteresis cascade that picks the next turning mode from the angle magnitude.
// Depends on dtc_pkg.
`default_nettype none

module dtc_mode_next
   import dtc_pkg::*;
(
   input  turn_mode_type      mode_cur,
   input  logic [MAG_W-1:0]   mag,
   input  logic [THR_W-1:0]   hard_thr,
   input  logic [THR_W-1:0]   soft_thr,
   input  logic [THR_W-1:0]   straight_thr,
   output turn_mode_type      mode_next
);

   logic          above_hard;
   logic          above_soft;
   logic          above_straight;
   turn_mode_type m0;
   turn_mode_type m1;
   turn_mode_type m2;

   // Compare the magnitude against the three thresholds
   assign above_hard     = mag > {2'b00, hard_thr};
   assign above_soft     = mag > {2'b00, soft_thr};
   assign above_straight = mag > {2'b00, straight_thr};

   // Walk the cascade: hard may drop to soft, soft moves on, straight moves on
   always_comb begin
      case (mode_cur)
         MODE_HARD:     m0 = MODE_HARD;
         MODE_SOFT:     m0 = MODE_SOFT;
         default:       m0 = MODE_STRAIGHT;
      endcase

      m1 = m0;
      if (m0 == MODE_HARD && !above_soft) begin
         m1 = MODE_SOFT;
      end

      m2 = m1;
      if (m1 == MODE_SOFT) begin
         if (above_hard) begin
            m2 = MODE_HARD;
         end else if (!above_straight) begin
            m2 = MODE_STRAIGHT;
         end
      end

      mode_next = m2;
      if (m2 == MODE_STRAIGHT) begin
         if (above_hard) begin
            mode_next = MODE_HARD;
         end else if (above_straight) begin
            mode_next = MODE_SOFT;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dtc_div_unit.sv =====
// Restoring divider, one quotient bit per cycle.
// The dividend must be below divisor * 2^16. Depends on dtc_pkg.
`default_nettype none

module dtc_div_unit
   import dtc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  div_ctrl_type   ctrl,
   output div_result_type result
);

   logic               busy_ff,  busy_in;
   logic               done_ff,  done_in;
   logic [3:0]         cnt_ff,   cnt_in;
   logic [THR_W-1:0]   rem_ff,   rem_in;
   logic [SPEED_W-1:0] low_ff,   low_in;
   logic [THR_W-1:0]   den_ff,   den_in;
   logic [THR_W:0]     trial;
   logic [THR_W:0]     diff;
   logic               ge;

   // One subtract-and-compare step
   assign trial = {rem_ff, low_ff[SPEED_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   // Load on start, then shift one quotient bit in per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = ctrl.dividend[PROD_W-1:SPEED_W];
         low_in  = ctrl.dividend[SPEED_W-1:0];
         den_in  = ctrl.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[THR_W-1:0] : trial[THR_W-1:0];
         low_in = {low_ff[SPEED_W-2:0], ge};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign result.done        = done_ff;
   assign result.quotient    = low_ff;
   assign result.rem_nonzero = rem_ff != '0;

endmodule

`default_nettype wire

// ===== hw/rtl/differential_drive_turn_control_unit.sv =====
// Differential drive turn control: each request (signed heading angle in
// Q2.13 radians, heading length in 1/256 speed units) yields one response
// with left and right wheel speeds and the turning mode after the step.
// The mode (straight, soft, hard) moves with hysteresis on the angle
// magnitude. One request is in flight at a time: req ready is high only
// while the unit is idle. Straight and hard steps go from acceptance via
// S_EVAL and S_FINISH to response valid in S_RESP; soft steps with a
// nonzero hard threshold add S_MUL, which forms base*|a|, then S_LOAD and
// S_DIV, where the serial divider divides it by H. A new request can be
// taken the cycle after the response is accepted. Registers on the csr
// port must be written only while idle; the unit does not enforce this.
// Depends on dtc_pkg, the channel interfaces, dtc_mode_next, dtc_div_unit.
`default_nettype none

module differential_drive_turn_control_unit
   import dtc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dtc_req_if.sink               req_ch,
   dtc_rsp_if.source             rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SPEED_W-1:0]    csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_MUL,
      S_LOAD,
      S_DIV,
      S_FINISH,
      S_RESP
   } state_type;

   state_type              state_ff;
   logic [THR_W-1:0]       hard_thr_ff;
   logic [THR_W-1:0]       soft_thr_ff;
   logic [THR_W-1:0]       straight_thr_ff;
   logic [SPEED_W-1:0]     max_speed_ff;
   turn_mode_type          mode_ff;
   logic [ANGLE_W-1:0]     angle_ff;
   logic [SPEED_W-1:0]     length_ff;
   logic [SPEED_W-1:0]     base_ff;
   logic [THR_W-1:0]       mag_ff;
   logic                   pos_ff;
   logic [PROD_W-1:0]      product_ff;
   logic                   rsp_valid_ff;
   logic signed [OUT_W-1:0] left_ff;
   logic signed [OUT_W-1:0] right_ff;

   logic [MAG_W-1:0]       mag;
   logic [SPEED_W-1:0]     base;
   turn_mode_type          mode_in;
   div_ctrl_type           div_ctrl;
   div_result_type         div_res;
   logic [OUT_W-1:0]       fast_sum;
   logic [SPEED_W-1:0]     fast_soft;
   logic [SPEED_W-1:0]     slow_soft;
   logic signed [OUT_W-1:0] slow_in;
   logic signed [OUT_W-1:0] fast_in;

   // Magnitude of the angle; the most negative code gives 32768
   assign mag  = angle_ff[ANGLE_W-1] ? (17'd65536 - {1'b0, angle_ff})
                                     : {1'b0, angle_ff};
   assign base = (length_ff < max_speed_ff) ? length_ff : max_speed_ff;

   dtc_mode_next u_mode_next (
      .mode_cur     (mode_ff),
      .mag          (mag),
      .hard_thr     (hard_thr_ff),
      .soft_thr     (soft_thr_ff),
      .straight_thr (straight_thr_ff),
      .mode_next    (mode_in)
   );

   assign div_ctrl.start    = state_ff == S_LOAD;
   assign div_ctrl.dividend = product_ff;
   assign div_ctrl.divisor  = hard_thr_ff;

   dtc_div_unit u_div_unit (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (div_ctrl),
      .result (div_res)
   );

   // Soft wheels: slow = base - ceil(base*|a|/H), fast = base + floor(...)
   assign fast_sum  = {1'b0, base_ff} + {1'b0, div_res.quotient};
   assign fast_soft = fast_sum[OUT_W-1] ? {SPEED_W{1'b1}} : fast_sum[SPEED_W-1:0];
   assign slow_soft = base_ff - div_res.quotient - {{(SPEED_W-1){1'b0}}, div_res.rem_nonzero};

   // Pick slow and fast wheel speeds for the settled mode
   always_comb begin
      case (mode_ff)
         MODE_SOFT: begin
            if (hard_thr_ff == '0) begin
               slow_in = $signed({1'b0, base_ff});
               fast_in = $signed({1'b0, base_ff});
            end else begin
               slow_in = $signed({1'b0, slow_soft});
               fast_in = $signed({1'b0, fast_soft});
            end
         end
         MODE_HARD: begin
            slow_in = -$signed({1'b0, max_speed_ff});
            fast_in = $signed({1'b0, max_speed_ff});
         end
         default: begin
            slow_in = $signed({1'b0, base_ff});
            fast_in = $signed({1'b0, base_ff});
         end
      endcase
   end

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hard_thr_ff     <= HARD_THR_RESET;
         soft_thr_ff     <= SOFT_THR_RESET;
         straight_thr_ff <= STRAIGHT_THR_RESET;
         max_speed_ff    <= MAX_SPEED_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HARD_THR:     hard_thr_ff     <= csr_write_data[THR_W-1:0];
            CSR_SOFT_THR:     soft_thr_ff     <= csr_write_data[THR_W-1:0];
            CSR_STRAIGHT_THR: straight_thr_ff <= csr_write_data[THR_W-1:0];
            CSR_MAX_SPEED:    max_speed_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Sequence one request: evaluate, optionally divide, finish, respond
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_STRAIGHT;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               mode_ff <= mode_in;
               if (mode_in == MODE_SOFT && hard_thr_ff != '0) begin
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_MUL: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_res.done) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end

      // Payload registers
      if (state_ff == S_IDLE && req_ch.valid) begin
         angle_ff  <= req_ch.heading_angle;
         length_ff <= req_ch.heading_length;
      end
      if (state_ff == S_EVAL) begin
         base_ff <= base;
         mag_ff  <= mag[THR_W-1:0];
         pos_ff  <= !angle_ff[ANGLE_W-1] && (angle_ff != '0);
      end
      if (state_ff == S_MUL) begin
         product_ff <= base_ff * mag_ff;
      end
      if (state_ff == S_FINISH) begin
         left_ff  <= pos_ff ? slow_in : fast_in;
         right_ff <= pos_ff ? fast_in : slow_in;
      end
   end

   assign req_ch.ready       = state_ff == S_IDLE;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.left_speed  = left_ff;
   assign rsp_ch.right_speed = right_ff;
   assign rsp_ch.turn_mode   = mode_ff;

endmodule

`default_nettype wire
